>>> rtl/core/gie_pkg.sv
`default_nettype none

package gie_pkg;

  localparam int NUM_GEARS_DEF    = 8;
  localparam int NUM_CHANNELS_DEF = 5;

  localparam int SAMPLE_W   = 10;
  localparam int OCTET_W    = 8;
  localparam int CHAN_W     = 3;
  localparam int GEAR_W_MAX = 4;
  localparam int NUM_SEG    = 8;
  localparam int NUM_TAGS   = 8;

  typedef logic [OCTET_W-1:0] octet_t;
  typedef logic [CHAN_W-1:0]  chan_t;

  localparam chan_t BRAKE_CHANNEL = 3'd2;
  localparam chan_t ACCEL_CHANNEL = 3'd3;

  localparam int     LADDER_STEPS = 9;
  localparam int     DUTY_STEP    = 28;
  localparam octet_t DUTY_MAX     = 8'(LADDER_STEPS * DUTY_STEP);

  localparam octet_t BRAKE_BOUNDS [LADDER_STEPS] =
    '{8'd150, 8'd155, 8'd160, 8'd165, 8'd170, 8'd175, 8'd180, 8'd185, 8'd195};
  localparam octet_t ACCEL_BOUNDS [LADDER_STEPS] =
    '{8'd130, 8'd135, 8'd140, 8'd145, 8'd150, 8'd155, 8'd160, 8'd165, 8'd170};

  localparam octet_t SEG_TABLE [NUM_SEG] =
    '{8'h7E, 8'h12, 8'hBC, 8'hB6, 8'hD2, 8'hE6, 8'hEE, 8'h32};
  localparam octet_t SEG_BLANK = 8'h00;

  // x y f a s, then digits for channels beyond the fifth
  localparam octet_t CHAN_TAG [NUM_TAGS] =
    '{8'h78, 8'h79, 8'h66, 8'h61, 8'h73, 8'h35, 8'h36, 8'h37};
  localparam octet_t TAG_BUTTON = 8'h62;
  localparam octet_t ASCII_ZERO = 8'h30;

  // one-cold button codes, active low
  localparam octet_t BTN_1  = 8'hFE;
  localparam octet_t BTN_2  = 8'hFD;
  localparam octet_t BTN_3  = 8'hFB;
  localparam octet_t BTN_4  = 8'hF7;
  localparam octet_t BTN_5  = 8'hEF;
  localparam octet_t BTN_6  = 8'hDF;
  localparam octet_t BTN_L1 = 8'hBF;
  localparam octet_t BTN_R1 = 8'h7F;

  localparam logic [3:0] CODE_RELEASE = 4'd0;
  localparam logic [3:0] CODE_B1      = 4'd1;
  localparam logic [3:0] CODE_B2      = 4'd2;
  localparam logic [3:0] CODE_B3      = 4'd3;
  localparam logic [3:0] CODE_B4      = 4'd4;
  localparam logic [3:0] CODE_B5      = 4'd5;
  localparam logic [3:0] CODE_B6      = 4'd6;
  localparam logic [3:0] CODE_L1      = 4'd7;
  localparam logic [3:0] CODE_R1      = 4'd8;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
    octet_t              button_byte;
  } in_item_t;

  typedef struct packed {
    octet_t tag;
    octet_t value;
    octet_t brake_duty;
    octet_t accel_duty;
    chan_t  mux_select;
  } analog_res_t;

  typedef struct packed {
    octet_t value;
    octet_t segment_pattern;
  } button_res_t;

  function automatic octet_t ladder(input octet_t bounds [LADDER_STEPS], input octet_t v);
    octet_t duty;
    duty = '0;
    for (int i = LADDER_STEPS - 1; i >= 0; i--) begin
      if (v <= bounds[i]) begin
        duty = 8'((LADDER_STEPS - i) * DUTY_STEP);
      end
    end
    return duty;
  endfunction

  function automatic octet_t seg_pattern(input logic [GEAR_W_MAX-1:0] g);
    octet_t pat;
    if (g < GEAR_W_MAX'(NUM_SEG)) begin
      pat = SEG_TABLE[g[2:0]];
    end else begin
      pat = SEG_BLANK;
    end
    return pat;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/gie_in_if.sv
`default_nettype none

interface gie_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [gie_pkg::SAMPLE_W-1:0]  sample;
  gie_pkg::octet_t               button_byte;

  modport source (output valid, output kind, output sample, output button_byte,
                  input ready);
  modport sink   (input valid, input kind, input sample, input button_byte,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/gie_out_if.sv
`default_nettype none

interface gie_out_if;
  logic            valid;
  logic            ready;
  gie_pkg::octet_t tag;
  gie_pkg::octet_t report_value;
  gie_pkg::octet_t brake_duty;
  gie_pkg::octet_t accel_duty;
  gie_pkg::octet_t segment_pattern;
  gie_pkg::chan_t  mux_select;

  modport source (output valid, output tag, output report_value, output brake_duty,
                  output accel_duty, output segment_pattern, output mux_select,
                  input ready);
  modport sink   (input valid, input tag, input report_value, input brake_duty,
                  input accel_duty, input segment_pattern, input mux_select,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/gamepad_input_encoder.sv
// Gamepad input encoder. Each transfer on in_bus (an analog sample or an
// expander button byte) yields exactly one report on out_bus. The block is an
// input register followed by a result register with the encoding logic between
// them: it takes one item per cycle while out_bus is not stalled, and each item
// passes through the input register and then the result register, from which
// its report is presented on out_bus. A stall holds the result register and
// then the input register; in_bus.ready drops only when both are full and
// out_bus.ready is low. The duty, gear and mux_select fields always show the
// state after the item.

`default_nettype none

module gamepad_input_encoder #(
  parameter int NUM_GEARS    = gie_pkg::NUM_GEARS_DEF,
  parameter int NUM_CHANNELS = gie_pkg::NUM_CHANNELS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  gie_in_if.sink    in_bus,
  gie_out_if.source out_bus
);

  logic                 s1_valid_r, s1_valid_nxt;
  gie_pkg::in_item_t    s1_item_r;
  logic                 out_valid_r, out_valid_nxt;
  gie_pkg::octet_t      out_tag_r, out_value_r, out_brake_r, out_accel_r, out_seg_r;
  gie_pkg::chan_t       out_mux_r;

  logic                 in_xfer;
  logic                 advance;
  logic                 s1_fire;
  gie_pkg::analog_res_t ares;
  gie_pkg::button_res_t bres;

  assign advance = !out_valid_r || out_bus.ready;
  assign s1_fire = s1_valid_r && advance;
  assign in_bus.ready = !s1_valid_r || advance;
  assign in_xfer = in_bus.valid && in_bus.ready;

  gie_analog #(.NUM_CHANNELS(NUM_CHANNELS)) u_analog (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (s1_fire && !s1_item_r.kind),
    .sample (s1_item_r.sample),
    .res    (ares)
  );

  gie_button #(.NUM_GEARS(NUM_GEARS)) u_button (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (s1_fire && s1_item_r.kind),
    .button_byte (s1_item_r.button_byte),
    .res         (bres)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.kind        <= in_bus.kind;
      s1_item_r.sample      <= in_bus.sample;
      s1_item_r.button_byte <= in_bus.button_byte;
    end
    if (s1_fire) begin
      out_tag_r   <= s1_item_r.kind ? gie_pkg::TAG_BUTTON : ares.tag;
      out_value_r <= s1_item_r.kind ? bres.value : ares.value;
      out_brake_r <= ares.brake_duty;
      out_accel_r <= ares.accel_duty;
      out_seg_r   <= bres.segment_pattern;
      out_mux_r   <= ares.mux_select;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.tag             = out_tag_r;
  assign out_bus.report_value    = out_value_r;
  assign out_bus.brake_duty      = out_brake_r;
  assign out_bus.accel_duty      = out_accel_r;
  assign out_bus.segment_pattern = out_seg_r;
  assign out_bus.mux_select      = out_mux_r;

  a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (s1_valid_r && out_valid_r && !out_bus.ready))
    else $error("input stalled while pipeline has room");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("staged item lost on its way to the result register");

  a_mux_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (32'(out_mux_r) < NUM_CHANNELS))
    else $error("mux_select beyond channel count");

  a_duty_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_brake_r <= gie_pkg::DUTY_MAX && out_accel_r <= gie_pkg::DUTY_MAX))
    else $error("duty beyond ladder maximum");

  a_button_keeps_mux: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_item_r.kind && out_valid_r) |=> (out_mux_r == $past(ares.mux_select)))
    else $error("button event moved the channel");

endmodule

`default_nettype wire

>>> rtl/core/gie_analog.sv
`default_nettype none

module gie_analog #(
  parameter int NUM_CHANNELS = gie_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         upd,
  input  wire logic [gie_pkg::SAMPLE_W-1:0] sample,
  output gie_pkg::analog_res_t              res
);

  gie_pkg::chan_t  chan_r,  chan_nxt;
  gie_pkg::octet_t brake_r, brake_nxt;
  gie_pkg::octet_t accel_r, accel_nxt;
  gie_pkg::octet_t value;
  logic [gie_pkg::CHAN_W:0] chan_inc;

  assign value    = sample[gie_pkg::SAMPLE_W-1:2];
  assign chan_inc = {1'b0, chan_r} + {{gie_pkg::CHAN_W{1'b0}}, 1'b1};

  always_comb begin
    chan_nxt  = chan_r;
    brake_nxt = brake_r;
    accel_nxt = accel_r;
    if (upd) begin
      if (chan_r == gie_pkg::BRAKE_CHANNEL) begin
        brake_nxt = gie_pkg::ladder(gie_pkg::BRAKE_BOUNDS, value);
      end else if (chan_r == gie_pkg::ACCEL_CHANNEL) begin
        accel_nxt = gie_pkg::ladder(gie_pkg::ACCEL_BOUNDS, value);
      end
      if (chan_inc >= (gie_pkg::CHAN_W + 1)'(NUM_CHANNELS)) begin
        chan_nxt = '0;
      end else begin
        chan_nxt = chan_inc[gie_pkg::CHAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r  <= '0;
      brake_r <= '0;
      accel_r <= '0;
    end else begin
      chan_r  <= chan_nxt;
      brake_r <= brake_nxt;
      accel_r <= accel_nxt;
    end
  end

  assign res.tag        = gie_pkg::CHAN_TAG[chan_r];
  assign res.value      = value;
  assign res.brake_duty = brake_nxt;
  assign res.accel_duty = accel_nxt;
  assign res.mux_select = chan_nxt;

endmodule

`default_nettype wire

>>> rtl/core/gie_button.sv
`default_nettype none

module gie_button #(
  parameter int NUM_GEARS = gie_pkg::NUM_GEARS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            upd,
  input  wire gie_pkg::octet_t button_byte,
  output gie_pkg::button_res_t res
);

  localparam int GW  = $clog2(NUM_GEARS);
  localparam int GMW = gie_pkg::GEAR_W_MAX;

  logic [GW-1:0] gear_r, gear_nxt;
  logic [GW:0]   gear_inc;
  logic [3:0]    code;

  assign gear_inc = {1'b0, gear_r} + {{GW{1'b0}}, 1'b1};

  always_comb begin
    unique case (button_byte)
      gie_pkg::BTN_1:  code = gie_pkg::CODE_B1;
      gie_pkg::BTN_2:  code = gie_pkg::CODE_B2;
      gie_pkg::BTN_3:  code = gie_pkg::CODE_B3;
      gie_pkg::BTN_4:  code = gie_pkg::CODE_B4;
      gie_pkg::BTN_5:  code = gie_pkg::CODE_B5;
      gie_pkg::BTN_6:  code = gie_pkg::CODE_B6;
      gie_pkg::BTN_L1: code = gie_pkg::CODE_L1;
      gie_pkg::BTN_R1: code = gie_pkg::CODE_R1;
      default:         code = gie_pkg::CODE_RELEASE;
    endcase
  end

  // saturating gear step
  always_comb begin
    gear_nxt = gear_r;
    if (upd) begin
      if (code == gie_pkg::CODE_L1 && gear_r != '0) begin
        gear_nxt = gear_r - {{(GW-1){1'b0}}, 1'b1};
      end else if (code == gie_pkg::CODE_R1 && gear_inc < (GW + 1)'(NUM_GEARS)) begin
        gear_nxt = gear_inc[GW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gear_r <= '0;
    end else begin
      gear_r <= gear_nxt;
    end
  end

  assign res.value           = gie_pkg::ASCII_ZERO + {4'b0000, code};
  assign res.segment_pattern = gie_pkg::seg_pattern(GMW'(gear_nxt));

endmodule

`default_nettype wire
